>>> rtl/gtj_pkg.sv
// shared types and constants for the greedy text justifier
package gtj_pkg;

    // default sizes of the line and the word list
    localparam int DEF_MAX_WIDTH = 32;
    localparam int DEF_MAX_WORDS = 16;

    // field widths fixed by the interface
    localparam int CHAR_W = 8;
    localparam int LW_W   = 6;

    // reset value of the line width register
    localparam logic [LW_W-1:0] LW_RST = 6'd16;

    // fill character for gaps and padding
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_EMIT,
        ST_COPY
    } state_t;

endpackage

>>> rtl/greedy_text_justifier.sv
// greedy fully justified text formatter, top level
// sequence: a character inside a word is taken in ST_IDLE; a word end is taken there, then
//   its stored letters are copied into the line one letter per cycle in ST_COPY
// a finished line passes the ST_PREP setup state, $clog2(MAX_WIDTH+1) divide steps when it is
//   justified, then one output character per cycle while out_ready holds
// throughput: one item at a time, set by the letter copy port and the shared subtractor
// reset: asynchronous active low; clears sequencer, counters and output valid, width 16
module greedy_text_justifier #(
    parameter int MAX_WIDTH = gtj_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WORDS = gtj_pkg::DEF_MAX_WORDS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gtj_pkg::LW_W-1:0]    cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gtj_pkg::CHAR_W-1:0]  char_in,
    input  logic                        word_end,
    input  logic                        text_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gtj_pkg::CHAR_W-1:0]  char_out,
    output logic                        line_done,
    output logic                        run_last
);
    import gtj_pkg::*;

    // counter and index widths
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCW = $clog2(MAX_WORDS + 1);
    localparam int WAW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int XW  = CW + 1;
    localparam int SW  = CW + 2;

    // letter and size stores
    logic [CHAR_W-1:0] line_mem [0:MAX_WIDTH-1];
    logic [CHAR_W-1:0] word_mem [0:MAX_WIDTH-1];
    logic [CW-1:0]     size_mem [0:MAX_WORDS-1];

    // control registers
    state_t          state_reg, state_next;
    logic [LW_W-1:0] lw_reg, lw_next;
    logic [WCW-1:0]  words_reg, words_next;
    logic [CW-1:0]   letters_reg, letters_next;
    logic [CW-1:0]   cws_reg, cws_next;
    logic            te_reg, te_next;
    logic            fin_reg, fin_next;
    logic [CW-1:0]   cp_reg, cp_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [WCW-1:0]  wi_reg, wi_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   src_reg, src_next;
    logic [XW-1:0]   wstart_reg, wstart_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ov_reg, ov_next;

    // payload registers
    logic [CW-1:0]     size_reg, size_next;
    logic [CW-1:0]     q_reg, q_next;
    logic [CW-1:0]     r_reg, r_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]     quo_reg, quo_next;
    logic [CHAR_W-1:0] co_reg, co_next;
    logic              ld_reg, ld_next;
    logic              rl_reg, rl_next;

    // derived values
    logic [CW-1:0]   w_eff;
    logic            in_acc;
    logic [CW-1:0]   cws_inc;
    logic [CW-1:0]   size_new;
    logic [SW-1:0]   fit_sum;
    logic            fits;
    logic [CW-1:0]   spare;
    logic [XW-1:0]   div_sh;
    logic [XW-1:0]   div_gaps;
    logic            div_ge;
    logic [XW-1:0]   div_diff;
    logic [CW-1:0]   rem_step;
    logic [CW-1:0]   quo_step;
    logic            emit_fire;
    logic            col_last;
    logic            in_word;
    logic [CW-1:0]   cur_size;
    logic            word_last;
    logic            gap_extra;
    logic [XW-1:0]   wstart_new;
    logic            copy_last;
    logic [CW-1:0]   copy_addr;

    // effective line width, clamped to 1..MAX_WIDTH
    always_comb
    begin
        if (lw_reg == '0)
            w_eff = CW'(1);
        else if (int'(lw_reg) > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(lw_reg);
    end

    // word end: clamped size and greedy fit test
    assign in_acc   = in_valid && in_ready;
    assign cws_inc  = (cws_reg < w_eff) ? CW'(cws_reg + CW'(1)) : cws_reg;
    assign size_new = (cws_inc < w_eff) ? cws_inc : w_eff;
    assign fit_sum  = SW'(letters_reg) + SW'(words_reg) + SW'(size_new);
    assign fits     = (words_reg == '0) ||
                      ((int'(words_reg) < MAX_WORDS) && (fit_sum <= SW'(w_eff)));

    // spare columns of the line
    assign spare = (letters_reg < w_eff) ? CW'(w_eff - letters_reg) : '0;

    // shared subtractor, one restoring divide step per cycle
    assign div_gaps = XW'(words_reg) - XW'(1);
    assign div_sh   = {rem_reg, quo_reg[CW-1]};
    assign div_ge   = (div_sh >= div_gaps);
    assign div_diff = div_sh - div_gaps;
    assign rem_step = div_ge ? CW'(div_diff) : CW'(div_sh);
    assign quo_step = CW'({quo_reg, div_ge});

    // output column walk
    assign emit_fire  = (state_reg == ST_EMIT) && (!ov_reg || out_ready);
    assign col_last   = (col_reg == CW'(w_eff - CW'(1)));
    assign in_word    = (wi_reg < words_reg) && (XW'(col_reg) >= wstart_reg);
    assign cur_size   = size_mem[wi_reg[WAW-1:0]];
    assign word_last  = (CW'(k_reg + CW'(1)) == cur_size);
    assign gap_extra  = ((XW'(wi_reg) + XW'(1)) <= XW'(r_reg));
    assign wstart_new = XW'(col_reg) + XW'(1) + XW'(q_reg) + XW'(gap_extra);

    // letter copy into the line
    assign copy_last = (CW'(cp_reg + CW'(1)) == size_reg);
    assign copy_addr = CW'(letters_reg + cp_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && word_end)
                    state_next = fits ? ST_COPY : ST_PREP;
            end
            ST_PREP:
            begin
                if ((words_reg > WCW'(1)) && !fin_reg)
                    state_next = ST_DIV;
                else
                    state_next = ST_EMIT;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire && col_last)
                    state_next = fin_reg ? ST_IDLE : ST_COPY;
            end
            ST_COPY:
            begin
                if (copy_last)
                    state_next = te_reg ? ST_PREP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = ov_reg;
        char_out  = co_reg;
        line_done = ld_reg;
        run_last  = rl_reg;
    end

    // datapath next values
    always_comb
    begin
        lw_next      = cfg_we ? cfg_wdata : lw_reg;
        words_next   = words_reg;
        letters_next = letters_reg;
        cws_next     = cws_reg;
        te_next      = te_reg;
        fin_next     = fin_reg;
        cp_next      = cp_reg;
        col_next     = col_reg;
        wi_next      = wi_reg;
        k_next       = k_reg;
        src_next     = src_reg;
        wstart_next  = wstart_reg;
        cnt_next     = cnt_reg;
        size_next    = size_reg;
        q_next       = q_reg;
        r_next       = r_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        co_next      = co_reg;
        ld_next      = ld_reg;
        rl_next      = rl_reg;
        ov_next      = (ov_reg && out_ready) ? 1'b0 : ov_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cws_next = cws_inc;
                    if (word_end)
                    begin
                        size_next = size_new;
                        te_next   = text_end;
                        fin_next  = 1'b0;
                        cp_next   = '0;
                    end
                end
            end
            ST_PREP:
            begin
                col_next    = '0;
                wi_next     = '0;
                k_next      = '0;
                src_next    = '0;
                wstart_next = '0;
                q_next      = CW'(1);
                r_next      = '0;
                rem_next    = '0;
                quo_next    = spare;
                cnt_next    = CW'(CW - 1);
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = CW'(cnt_reg - CW'(1));
                if (cnt_reg == '0)
                begin
                    q_next = quo_step;
                    r_next = rem_step;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    ov_next  = 1'b1;
                    co_next  = in_word ? line_mem[src_reg[AW-1:0]] : SPACE_CHAR;
                    ld_next  = col_last;
                    rl_next  = col_last && (fin_reg || !te_reg);
                    col_next = CW'(col_reg + CW'(1));
                    if (in_word)
                    begin
                        src_next = CW'(src_reg + CW'(1));
                        if (word_last)
                        begin
                            wi_next     = WCW'(wi_reg + WCW'(1));
                            k_next      = '0;
                            wstart_next = wstart_new;
                        end
                        else
                        begin
                            k_next = CW'(k_reg + CW'(1));
                        end
                    end
                    if (col_last)
                    begin
                        words_next   = '0;
                        letters_next = '0;
                        cp_next      = '0;
                        if (fin_reg)
                        begin
                            cws_next = '0;
                            te_next  = 1'b0;
                            fin_next = 1'b0;
                        end
                    end
                end
            end
            ST_COPY:
            begin
                cp_next = CW'(cp_reg + CW'(1));
                if (copy_last)
                begin
                    words_next   = WCW'(words_reg + WCW'(1));
                    letters_next = CW'(letters_reg + size_reg);
                    cws_next     = '0;
                    if (te_reg)
                        fin_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            lw_reg      <= LW_RST;
            words_reg   <= '0;
            letters_reg <= '0;
            cws_reg     <= '0;
            te_reg      <= 1'b0;
            fin_reg     <= 1'b0;
            cp_reg      <= '0;
            col_reg     <= '0;
            wi_reg      <= '0;
            k_reg       <= '0;
            src_reg     <= '0;
            wstart_reg  <= '0;
            cnt_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lw_reg      <= lw_next;
            words_reg   <= words_next;
            letters_reg <= letters_next;
            cws_reg     <= cws_next;
            te_reg      <= te_next;
            fin_reg     <= fin_next;
            cp_reg      <= cp_next;
            col_reg     <= col_next;
            wi_reg      <= wi_next;
            k_reg       <= k_next;
            src_reg     <= src_next;
            wstart_reg  <= wstart_next;
            cnt_reg     <= cnt_next;
            ov_reg      <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        co_reg   <= co_next;
        ld_reg   <= ld_next;
        rl_reg   <= rl_next;
    end

    // letter and size store writes
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_acc && (cws_reg < w_eff))
            word_mem[cws_reg[AW-1:0]] <= char_in;
        if (state_reg == ST_COPY)
        begin
            line_mem[copy_addr[AW-1:0]] <= word_mem[cp_reg[AW-1:0]];
            if (copy_last)
                size_mem[words_reg[WAW-1:0]] <= size_reg;
        end
    end

    // the line never holds more words or letters than it can
    assert property (@(posedge clk) disable iff (!rst_n)
        (int'(words_reg) <= MAX_WORDS) && (int'(letters_reg) <= MAX_WIDTH))
    else $error("line word or letter count out of range");

    // the output column stays inside the line while emitting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (col_reg < w_eff))
    else $error("output column beyond line width");

    // a character inside a word leaves the block ready for the next character
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !word_end) |=> in_ready)
    else $error("not ready after a mid-word character");

    // the last character of a run always ends a line
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && run_last) |-> line_done)
    else $error("run end without line end");

endmodule
